>>> rtl/core/usbcdc_pkg.sv
// Shared constants for the CDC-ACM configuration descriptor walker.
package usbcdc_pkg;

  // Standard descriptor type codes
  localparam logic [7:0] DESC_TYPE_IFACE = 8'h04;
  localparam logic [7:0] DESC_TYPE_EP    = 8'h05;

  // Interface class / subclass codes
  localparam logic [7:0] CLASS_COMM    = 8'h02;
  localparam logic [7:0] SUBCLASS_ACM  = 8'h02;
  localparam logic [7:0] CLASS_DATA    = 8'h0A;

  // Endpoint transfer types (bmAttributes[1:0])
  localparam logic [1:0] XFER_BULK = 2'h2;
  localparam logic [1:0] XFER_INT  = 2'h3;

  // Header byte positions and minimum header length
  localparam logic [15:0] OFF_HDR_LEN  = 16'd0;
  localparam logic [15:0] OFF_TOTAL_LO = 16'd2;
  localparam logic [15:0] OFF_TOTAL_HI = 16'd3;
  localparam logic [15:0] OFF_SUB_MIN  = 16'd4;
  localparam logic [7:0]  HDR_MIN_LEN  = 8'd4;
  localparam logic [15:0] OFF_MAX      = 16'hFFFF;

  // Byte positions inside a sub-descriptor
  localparam logic [15:0] REL_LEN      = 16'd0;
  localparam logic [15:0] REL_TYPE     = 16'd1;
  localparam logic [15:0] REL_NUM_ADDR = 16'd2;
  localparam logic [15:0] REL_ATTR     = 16'd3;
  localparam logic [15:0] REL_CLASS    = 16'd5;
  localparam logic [15:0] REL_SUBCLASS = 16'd6;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_IFACE  = 2'd1;
  localparam logic [1:0] ST_NO_BULK   = 2'd2;

endpackage

>>> rtl/core/usb_cdc_acm_descriptor_walker_unit.sv
// CDC-ACM configuration descriptor walker: one byte per cycle while in_stall is low, at most one result per buffer.
//
// Input channel (in_valid / in_stall): one descriptor byte per transaction.
// in_first_byte restarts the walk with this byte as byte 0; in_end_of_buffer
// marks the last byte and forces a result if none was given yet. Bytes that
// arrive after the result are dropped until the next in_first_byte.
// Result channel (out_valid / out_stall): at most one transaction per buffer with the
// status and the captured interface numbers and endpoint addresses.
// Throughput: one byte every cycle while in_stall is low; each byte needs only compares
// and captures in the walker state registers, updated at the accepting edge.
// out_valid is registered and rises in the cycle after the byte that ends the walk is taken.
// The result register is a single stage: while it holds a result and
// out_stall is high, in_stall is high; otherwise a byte is taken every cycle,
// also in the cycle the held result is taken.
// Reset (rst_n low, synchronous) clears the walk and the result valid; the
// first byte after reset is taken as byte 0 even without in_first_byte.
module usb_cdc_acm_descriptor_walker_unit
  import usbcdc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_first_byte,
  input  logic       in_end_of_buffer,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [7:0] out_ctrl_if_num,
  output logic [7:0] out_dat_if_num,
  output logic [7:0] out_irq_ep_addr,
  output logic [7:0] out_blk_in_addr,
  output logic [7:0] out_blk_out_addr
);

  logic [15:0] byte_offset_r, byte_offset_nxt;
  logic [15:0] total_length_r, total_length_nxt;
  logic [7:0]  header_length_r, header_length_nxt;
  logic [15:0] sub_start_r, sub_start_nxt;
  logic [7:0]  sub_length_r, sub_length_nxt;
  logic [7:0]  sub_type_r, sub_type_nxt;
  logic [7:0]  pend_iface_num_r, pend_iface_num_nxt;
  logic [7:0]  pend_iface_class_r, pend_iface_class_nxt;
  logic [7:0]  pend_ep_addr_r, pend_ep_addr_nxt;
  logic [7:0]  cur_iface_class_r, cur_iface_class_nxt;
  logic        iface_seen_r, iface_seen_nxt;
  logic        found_comm_r, found_comm_nxt;
  logic        found_data_r, found_data_nxt;
  logic [7:0]  ctrl_if_num_r, ctrl_if_num_nxt;
  logic [7:0]  dat_if_num_r, dat_if_num_nxt;
  logic [7:0]  irq_ep_addr_r, irq_ep_addr_nxt;
  logic [7:0]  blk_in_addr_r, blk_in_addr_nxt;
  logic [7:0]  blk_out_addr_r, blk_out_addr_nxt;
  logic        walk_done_r, walk_done_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, status_nxt;

  logic        in_acc;
  logic        emit;
  logic        done;
  logic [15:0] off;
  logic [15:0] rel;
  logic [16:0] next_start;
  logic [7:0]  b;

  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;
  assign b        = in_data_byte;

  always_comb begin
    // A restart begins from the cleared state.
    if (in_first_byte) begin
      byte_offset_nxt      = '0;
      total_length_nxt     = '0;
      header_length_nxt    = '0;
      sub_start_nxt        = '0;
      sub_length_nxt       = '0;
      sub_type_nxt         = '0;
      pend_iface_num_nxt   = '0;
      pend_iface_class_nxt = '0;
      pend_ep_addr_nxt     = '0;
      cur_iface_class_nxt  = '0;
      iface_seen_nxt       = 1'b0;
      found_comm_nxt       = 1'b0;
      found_data_nxt       = 1'b0;
      ctrl_if_num_nxt      = '0;
      dat_if_num_nxt       = '0;
      irq_ep_addr_nxt      = '0;
      blk_in_addr_nxt      = '0;
      blk_out_addr_nxt     = '0;
      walk_done_nxt        = 1'b0;
    end else begin
      byte_offset_nxt      = byte_offset_r;
      total_length_nxt     = total_length_r;
      header_length_nxt    = header_length_r;
      sub_start_nxt        = sub_start_r;
      sub_length_nxt       = sub_length_r;
      sub_type_nxt         = sub_type_r;
      pend_iface_num_nxt   = pend_iface_num_r;
      pend_iface_class_nxt = pend_iface_class_r;
      pend_ep_addr_nxt     = pend_ep_addr_r;
      cur_iface_class_nxt  = cur_iface_class_r;
      iface_seen_nxt       = iface_seen_r;
      found_comm_nxt       = found_comm_r;
      found_data_nxt       = found_data_r;
      ctrl_if_num_nxt      = ctrl_if_num_r;
      dat_if_num_nxt       = dat_if_num_r;
      irq_ep_addr_nxt      = irq_ep_addr_r;
      blk_in_addr_nxt      = blk_in_addr_r;
      blk_out_addr_nxt     = blk_out_addr_r;
      walk_done_nxt        = walk_done_r;
    end

    off        = byte_offset_nxt;
    rel        = off - sub_start_nxt;
    next_start = {1'b0, off} + 17'd1;
    done       = 1'b0;
    emit       = 1'b0;

    if (!walk_done_nxt) begin
      // Header bytes
      if (off == OFF_HDR_LEN) begin
        header_length_nxt = b;
        sub_start_nxt     = {8'h00, b};
        if (b < HDR_MIN_LEN) done = 1'b1;
      end else if (off == OFF_TOTAL_LO) begin
        total_length_nxt = {8'h00, b};
      end else if (off == OFF_TOTAL_HI) begin
        total_length_nxt = {b, total_length_nxt[7:0]};
        if ({8'h00, header_length_nxt} >= {b, total_length_nxt[7:0]}) begin
          done = 1'b1;
        end else begin
          sub_start_nxt = {8'h00, header_length_nxt};
        end
      end

      // Sub-descriptor bytes; sub_start is untouched above for these offsets
      if (!done && off >= OFF_SUB_MIN && off >= sub_start_nxt) begin
        case (rel)
          REL_LEN: begin
            if (b == 8'h00) done = 1'b1;
            else sub_length_nxt = b;
          end
          REL_TYPE: begin
            sub_type_nxt = b;
            if (b == DESC_TYPE_IFACE) begin
              iface_seen_nxt      = 1'b1;
              cur_iface_class_nxt = 8'h00;
            end
          end
          REL_NUM_ADDR: begin
            if (sub_type_nxt == DESC_TYPE_IFACE) pend_iface_num_nxt = b;
            else if (sub_type_nxt == DESC_TYPE_EP) pend_ep_addr_nxt = b;
          end
          REL_ATTR: begin
            if (sub_type_nxt == DESC_TYPE_EP && iface_seen_nxt) begin
              if (cur_iface_class_nxt == CLASS_COMM) begin
                if (pend_ep_addr_nxt[7] && b[1:0] == XFER_INT)
                  irq_ep_addr_nxt = pend_ep_addr_nxt;
              end else if (cur_iface_class_nxt == CLASS_DATA && b[1:0] == XFER_BULK) begin
                if (pend_ep_addr_nxt[7]) blk_in_addr_nxt = pend_ep_addr_nxt;
                else blk_out_addr_nxt = pend_ep_addr_nxt;
              end
            end
          end
          REL_CLASS: begin
            if (sub_type_nxt == DESC_TYPE_IFACE) begin
              pend_iface_class_nxt = b;
              cur_iface_class_nxt  = b;
              if (b == CLASS_DATA) begin
                dat_if_num_nxt = pend_iface_num_nxt;
                found_data_nxt = 1'b1;
              end
            end
          end
          REL_SUBCLASS: begin
            if (sub_type_nxt == DESC_TYPE_IFACE && pend_iface_class_nxt == CLASS_COMM &&
                b == SUBCLASS_ACM) begin
              ctrl_if_num_nxt = pend_iface_num_nxt;
              found_comm_nxt  = 1'b1;
            end
          end
          default: ;
        endcase

        // Last byte of this sub-descriptor: check the total, then move on
        if (!done && sub_length_nxt != 8'h00 &&
            rel == {8'h00, sub_length_nxt - 8'd1}) begin
          if (next_start >= {1'b0, total_length_nxt}) done = 1'b1;
          else sub_start_nxt = next_start[15:0];
        end
      end

      if (off != OFF_MAX) byte_offset_nxt = next_start[15:0];

      emit = done | in_end_of_buffer;
      if (emit) walk_done_nxt = 1'b1;
    end

    if (!found_comm_nxt || !found_data_nxt) status_nxt = ST_NO_IFACE;
    else if (blk_in_addr_nxt == 8'h00 || blk_out_addr_nxt == 8'h00) status_nxt = ST_NO_BULK;
    else status_nxt = ST_OK;

    if (in_acc && emit) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r      <= '0;
      total_length_r     <= '0;
      header_length_r    <= '0;
      sub_start_r        <= '0;
      sub_length_r       <= '0;
      sub_type_r         <= '0;
      pend_iface_num_r   <= '0;
      pend_iface_class_r <= '0;
      pend_ep_addr_r     <= '0;
      cur_iface_class_r  <= '0;
      iface_seen_r       <= 1'b0;
      found_comm_r       <= 1'b0;
      found_data_r       <= 1'b0;
      ctrl_if_num_r      <= '0;
      dat_if_num_r       <= '0;
      irq_ep_addr_r      <= '0;
      blk_in_addr_r      <= '0;
      blk_out_addr_r     <= '0;
      walk_done_r        <= 1'b0;
      out_valid_r        <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        byte_offset_r      <= byte_offset_nxt;
        total_length_r     <= total_length_nxt;
        header_length_r    <= header_length_nxt;
        sub_start_r        <= sub_start_nxt;
        sub_length_r       <= sub_length_nxt;
        sub_type_r         <= sub_type_nxt;
        pend_iface_num_r   <= pend_iface_num_nxt;
        pend_iface_class_r <= pend_iface_class_nxt;
        pend_ep_addr_r     <= pend_ep_addr_nxt;
        cur_iface_class_r  <= cur_iface_class_nxt;
        iface_seen_r       <= iface_seen_nxt;
        found_comm_r       <= found_comm_nxt;
        found_data_r       <= found_data_nxt;
        ctrl_if_num_r      <= ctrl_if_num_nxt;
        dat_if_num_r       <= dat_if_num_nxt;
        irq_ep_addr_r      <= irq_ep_addr_nxt;
        blk_in_addr_r      <= blk_in_addr_nxt;
        blk_out_addr_r     <= blk_out_addr_nxt;
        walk_done_r        <= walk_done_nxt;
      end
    end
  end

  // Result payload: loaded only with a new result
  logic [7:0] res_comm_r, res_data_r, res_int_r, res_bin_r, res_bout_r;

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_status_r <= status_nxt;
      res_comm_r   <= ctrl_if_num_nxt;
      res_data_r   <= dat_if_num_nxt;
      res_int_r    <= irq_ep_addr_nxt;
      res_bin_r    <= blk_in_addr_nxt;
      res_bout_r   <= blk_out_addr_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_ctrl_if_num  = res_comm_r;
  assign out_dat_if_num   = res_data_r;
  assign out_irq_ep_addr  = res_int_r;
  assign out_blk_in_addr  = res_bin_r;
  assign out_blk_out_addr = res_bout_r;

`ifndef SYNTHESIS
  // Once the result is given, later bytes of the same buffer leave the walk alone.
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && walk_done_r && !in_first_byte) |=>
      (walk_done_r && $stable(byte_offset_r) && $stable(blk_in_addr_r)))
    else $error("walker state changed after the result was given");

  // A result transaction always leaves the walk finished.
  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && emit) |=> (out_valid && walk_done_r))
    else $error("result emitted without ending the walk");

  // An ok status implies both bulk endpoints were captured.
  a_ok_bulk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK) |->
      (out_blk_in_addr != 8'h00 && out_blk_out_addr != 8'h00))
    else $error("ok status with a missing bulk endpoint");
`endif

endmodule

>>> sim/usb_cdc_acm_descriptor_walker_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the CDC-ACM configuration descriptor walker unit.
module usb_cdc_acm_descriptor_walker_unit_tb
  import usbcdc_pkg::*;
();

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] ctrl_if_num;
    logic [7:0] dat_if_num;
    logic [7:0] irq_ep_addr;
    logic [7:0] blk_in_addr;
    logic [7:0] blk_out_addr;
  } walk_result_t;

  localparam logic [7:0] DESC_TYPE_CONFIG = 8'h02;
  localparam logic [7:0] DESC_TYPE_IAD    = 8'h0B;
  localparam logic [7:0] DESC_TYPE_CS_IF  = 8'h24;
  localparam logic [7:0] CLASS_HID        = 8'h03;
  localparam logic [1:0] XFER_ISO         = 2'h1;
  localparam int         ITEM_TARGET      = 1900;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_first_byte = 1'b0;
  logic       in_end_of_buffer = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [1:0] out_status;
  logic [7:0] out_ctrl_if_num;
  logic [7:0] out_dat_if_num;
  logic [7:0] out_irq_ep_addr;
  logic [7:0] out_blk_in_addr;
  logic [7:0] out_blk_out_addr;

  usb_cdc_acm_descriptor_walker_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_first_byte    (in_first_byte),
    .in_end_of_buffer (in_end_of_buffer),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_ctrl_if_num  (out_ctrl_if_num),
    .out_dat_if_num   (out_dat_if_num),
    .out_irq_ep_addr  (out_irq_ep_addr),
    .out_blk_in_addr  (out_blk_in_addr),
    .out_blk_out_addr (out_blk_out_addr)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #(4_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  // Walker state mirror
  logic [15:0] walk_pos;
  logic [15:0] walk_total;
  logic [15:0] walk_base;
  logic [7:0]  walk_hdr_len;
  logic [7:0]  walk_sub_len;
  logic [7:0]  walk_sub_kind;
  logic [7:0]  pend_iface_num;
  logic [7:0]  pend_iface_class;
  logic [7:0]  pend_ep_addr;
  logic [7:0]  cur_class;
  bit          iface_open;
  bit          have_comm;
  bit          have_data;
  bit          walk_over;
  logic [7:0]  cap_comm;
  logic [7:0]  cap_data;
  logic [7:0]  cap_int_in;
  logic [7:0]  cap_bulk_in;
  logic [7:0]  cap_bulk_out;

  walk_result_t pending_results[$];
  walk_result_t head_result;
  logic [7:0]   buf_bytes[$];
  int           sent_items = 0;
  int           error_count = 0;
  bit           steady_flow = 1'b0;

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  function automatic void log_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("[%0t] ERROR: %s", $time, msg);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want_v,
                                      input logic [7:0] got_v);
    if (got_v !== want_v)
      log_error($sformatf("%s: expected 0x%02h, got 0x%02h", name, want_v, got_v));
  endfunction

  function automatic void walk_clear();
    walk_pos = '0;
    walk_total = '0;
    walk_base = '0;
    walk_hdr_len = '0;
    walk_sub_len = '0;
    walk_sub_kind = '0;
    pend_iface_num = '0;
    pend_iface_class = '0;
    pend_ep_addr = '0;
    cur_class = '0;
    iface_open = 1'b0;
    have_comm = 1'b0;
    have_data = 1'b0;
    walk_over = 1'b0;
    cap_comm = '0;
    cap_data = '0;
    cap_int_in = '0;
    cap_bulk_in = '0;
    cap_bulk_out = '0;
  endfunction

  function automatic void capture_endpoint(input logic [7:0] attr);
    if (!iface_open) return;
    if (cur_class == CLASS_COMM) begin
      if (pend_ep_addr[7] && attr[1:0] == XFER_INT) cap_int_in = pend_ep_addr;
    end else if (cur_class == CLASS_DATA && attr[1:0] == XFER_BULK) begin
      if (pend_ep_addr[7]) cap_bulk_in = pend_ep_addr;
      else cap_bulk_out = pend_ep_addr;
    end
  endfunction

  // Advance the mirror by one accepted byte; queue the result when the walk ends.
  function automatic void walk_byte(input logic [7:0] b, input logic fb, input logic eob);
    int off;
    int rel;
    bit done;
    walk_result_t r;
    if (fb) walk_clear();
    if (walk_over) return;
    done = 1'b0;
    off = walk_pos;
    if (off == OFF_HDR_LEN) begin
      walk_hdr_len = b;
      walk_base = {8'h00, b};
      if (b < HDR_MIN_LEN) done = 1'b1;
    end else if (off == OFF_TOTAL_LO) begin
      walk_total = {8'h00, b};
    end else if (off == OFF_TOTAL_HI) begin
      walk_total[15:8] = b;
      if ({8'h00, walk_hdr_len} >= walk_total) done = 1'b1;
      else walk_base = {8'h00, walk_hdr_len};
    end
    if (!done && off >= OFF_SUB_MIN && off >= walk_base) begin
      rel = off - walk_base;
      if (rel == REL_LEN) begin
        if (b == 8'h00) done = 1'b1;
        else walk_sub_len = b;
      end else if (rel == REL_TYPE) begin
        walk_sub_kind = b;
        if (b == DESC_TYPE_IFACE) begin
          iface_open = 1'b1;
          cur_class = 8'h00;
        end
      end else if (rel == REL_NUM_ADDR) begin
        if (walk_sub_kind == DESC_TYPE_IFACE) pend_iface_num = b;
        else if (walk_sub_kind == DESC_TYPE_EP) pend_ep_addr = b;
      end else if (rel == REL_ATTR) begin
        if (walk_sub_kind == DESC_TYPE_EP) capture_endpoint(b);
      end else if (rel == REL_CLASS) begin
        if (walk_sub_kind == DESC_TYPE_IFACE) begin
          pend_iface_class = b;
          cur_class = b;
          if (b == CLASS_DATA) begin
            cap_data = pend_iface_num;
            have_data = 1'b1;
          end
        end
      end else if (rel == REL_SUBCLASS) begin
        if (walk_sub_kind == DESC_TYPE_IFACE && pend_iface_class == CLASS_COMM &&
            b == SUBCLASS_ACM) begin
          cap_comm = pend_iface_num;
          have_comm = 1'b1;
        end
      end
      // total length is checked against the start of the next sub-descriptor
      if (!done && walk_sub_len != 8'h00 && rel == int'(walk_sub_len) - 1) begin
        if (off + 1 >= walk_total) done = 1'b1;
        else walk_base = 16'(off + 1);
      end
    end
    if (walk_pos < OFF_MAX) walk_pos = 16'(off + 1);
    if (!done && !eob) return;
    walk_over = 1'b1;
    if (!have_comm || !have_data) r.status = ST_NO_IFACE;
    else if (cap_bulk_in == 8'h00 || cap_bulk_out == 8'h00) r.status = ST_NO_BULK;
    else r.status = ST_OK;
    r.ctrl_if_num = cap_comm;
    r.dat_if_num = cap_data;
    r.irq_ep_addr = cap_int_in;
    r.blk_in_addr = cap_bulk_in;
    r.blk_out_addr = cap_bulk_out;
    pending_results.push_back(r);
  endfunction

  always @(posedge clk) begin
    out_stall <= rst_n && !steady_flow && ($urandom_range(99) < 17);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        log_error($sformatf("result transaction with none expected, status %0d", out_status));
      end else begin
        head_result = pending_results.pop_front();
        check_field("status", 8'(head_result.status), 8'(out_status));
        check_field("ctrl_if_num", head_result.ctrl_if_num, out_ctrl_if_num);
        check_field("dat_if_num", head_result.dat_if_num, out_dat_if_num);
        check_field("irq_ep_addr", head_result.irq_ep_addr, out_irq_ep_addr);
        check_field("blk_in_addr", head_result.blk_in_addr, out_blk_in_addr);
        check_field("blk_out_addr", head_result.blk_out_addr, out_blk_out_addr);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fb, input logic eob);
    while (!steady_flow && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_first_byte <= fb;
    in_end_of_buffer <= eob;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
    walk_byte(b, fb, eob);
  endtask

  task automatic send_buffer(input bit restart, input int eob_at);
    for (int i = 0; i < buf_bytes.size(); i++)
      send_byte(buf_bytes[i], restart && i == 0, i == eob_at);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Descriptor builders
  function automatic void start_config(input int hdr_len);
    buf_bytes.delete();
    buf_bytes.push_back(8'(hdr_len));
    buf_bytes.push_back(DESC_TYPE_CONFIG);
    buf_bytes.push_back(8'h00);
    buf_bytes.push_back(8'h00);
    for (int i = 4; i < hdr_len; i++) buf_bytes.push_back(rand_byte());
  endfunction

  function automatic void set_total(input int total);
    buf_bytes[2] = total[7:0];
    buf_bytes[3] = total[15:8];
  endfunction

  function automatic void add_desc(input int len, input logic [7:0] kind,
                                   input logic [7:0] f2, input logic [7:0] f3,
                                   input logic [7:0] f5, input logic [7:0] f6);
    if (len == 0) buf_bytes.push_back(8'h00);
    for (int i = 0; i < len; i++)
      case (i)
        0: buf_bytes.push_back(8'(len));
        1: buf_bytes.push_back(kind);
        2: buf_bytes.push_back(f2);
        3: buf_bytes.push_back(f3);
        5: buf_bytes.push_back(f5);
        6: buf_bytes.push_back(f6);
        default: buf_bytes.push_back(rand_byte());
      endcase
  endfunction

  function automatic void add_iface(input int len, input logic [7:0] num,
                                    input logic [7:0] cls, input logic [7:0] subcls);
    add_desc(len, DESC_TYPE_IFACE, num, rand_byte(), cls, subcls);
  endfunction

  function automatic void add_ep(input int len, input logic [7:0] addr, input logic [1:0] xfer);
    add_desc(len, DESC_TYPE_EP, addr, {6'($urandom), xfer}, rand_byte(), rand_byte());
  endfunction

  function automatic logic [7:0] ep_in();
    return {1'b1, 7'($urandom)};
  endfunction

  function automatic logic [7:0] ep_out();
    return {4'h0, 4'($urandom_range(1, 15))};
  endfunction

  function automatic void add_cs_desc(input int len);
    add_desc(len, DESC_TYPE_CS_IF, rand_byte(), rand_byte(), rand_byte(), rand_byte());
  endfunction

  function automatic void add_acm_function(input logic [7:0] comm, input logic [7:0] data,
                                           input logic [7:0] int_ep, input logic [7:0] bin,
                                           input logic [7:0] bout);
    add_iface(9, comm, CLASS_COMM, SUBCLASS_ACM);
    add_cs_desc(5);
    add_cs_desc(5);
    add_cs_desc(4);
    add_cs_desc(5);
    add_ep(7, int_ep, XFER_INT);
    add_iface(9, data, CLASS_DATA, 8'h00);
    add_ep(7, bout, XFER_BULK);
    add_ep(7, bin, XFER_BULK);
  endfunction

  function automatic void build_standard(input logic [7:0] comm, input logic [7:0] data,
                                         input logic [7:0] int_ep, input logic [7:0] bin,
                                         input logic [7:0] bout);
    start_config(9);
    add_desc(8, DESC_TYPE_IAD, comm, 8'h02, CLASS_COMM, SUBCLASS_ACM);
    add_acm_function(comm, data, int_ep, bin, bout);
    set_total(buf_bytes.size());
  endfunction

  function automatic int maybe_short(input int len);
    return ($urandom_range(3) == 0) ? $urandom_range(1, len + 3) : len;
  endfunction

  function automatic void add_random_piece();
    case ($urandom_range(6))
      0: add_iface(maybe_short(9), rand_byte(),
                   $urandom_range(1) ? CLASS_COMM : rand_byte(),
                   $urandom_range(1) ? SUBCLASS_ACM : rand_byte());
      1: add_iface(maybe_short(9), rand_byte(), CLASS_DATA, rand_byte());
      2: add_ep(maybe_short(7), $urandom_range(1) ? ep_in() : ep_out(), 2'($urandom));
      3: add_ep(7, ep_in(), XFER_BULK);
      4: add_ep(7, ep_out(), XFER_BULK);
      5: add_cs_desc($urandom_range(1, 12));
      default: add_desc($urandom_range(1, 20), rand_byte(), rand_byte(), rand_byte(),
                        rand_byte(), rand_byte());
    endcase
  endfunction

  function automatic void build_random_config();
    int hdr;
    hdr = ($urandom_range(7) == 0) ? $urandom_range(4, 12) : 9;
    start_config(hdr);
    if ($urandom_range(1) == 1)
      add_desc(8, DESC_TYPE_IAD, rand_byte(), rand_byte(), rand_byte(), rand_byte());
    if ($urandom_range(3) == 0) begin
      // unrelated interface ahead of the ACM pair; its endpoint must not be taken
      add_iface(9, rand_byte(), CLASS_HID, rand_byte());
      add_ep(7, ep_in(), XFER_INT);
    end
    if ($urandom_range(9) < 7)
      add_acm_function(rand_byte(), rand_byte(), ep_in(), ep_in(), ep_out());
    repeat ($urandom_range(6)) add_random_piece();
    set_total(buf_bytes.size());
  endfunction

  // Directed tests
  task automatic test_no_restart_after_reset();
    build_standard(8'h00, 8'h01, 8'h82, 8'h81, 8'h01);
    send_buffer(1'b0, buf_bytes.size() - 1);
  endtask

  task automatic test_standard_config();
    build_standard(8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F);
    send_buffer(1'b1, buf_bytes.size() - 1);
    // ends on total length alone; trailing bytes and the end marker are ignored
    build_standard(8'h5A, 8'hA5, 8'h83, 8'h84, 8'h05);
    repeat (4) buf_bytes.push_back(rand_byte());
    send_buffer(1'b1, buf_bytes.size() - 1);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0);
  endtask

  task automatic test_short_header();
    for (int h = 0; h < 4; h++) begin
      start_config(4);
      buf_bytes[0] = 8'(h);
      add_acm_function(8'h01, 8'h02, 8'h81, 8'h82, 8'h03);
      set_total(buf_bytes.size());
      send_buffer(1'b1, -1);
    end
    start_config(255);
    add_acm_function(8'h05, 8'h06, 8'h8F, 8'hFF, 8'h7F);
    set_total(buf_bytes.size());
    send_buffer(1'b1, -1);
  endtask

  task automatic test_header_reaches_total();
    for (int k = 0; k < 4; k++) begin
      start_config(9);
      add_acm_function(8'h01, 8'h02, 8'h81, 8'h82, 8'h03);
      set_total((k == 0) ? 0 : (k == 1) ? 4 : (k == 2) ? 8 : 9);
      send_buffer(1'b1, -1);
    end
    start_config(4);
    add_acm_function(8'h10, 8'h11, 8'h86, 8'h87, 8'h08);
    set_total(buf_bytes.size());
    send_buffer(1'b1, -1);
  endtask

  task automatic test_zero_length();
    start_config(9);
    add_iface(9, 8'h01, CLASS_COMM, SUBCLASS_ACM);
    add_ep(7, 8'h81, XFER_INT);
    add_desc(0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    add_iface(9, 8'h02, CLASS_DATA, 8'h00);
    add_ep(7, 8'h82, XFER_BULK);
    add_ep(7, 8'h02, XFER_BULK);
    set_total(buf_bytes.size());
    send_buffer(1'b1, -1);
  endtask

  task automatic test_short_descriptors();
    start_config(9);
    add_iface(5, 8'h03, CLASS_DATA, 8'h00);        // class byte missing: class 0
    add_ep(7, 8'h88, XFER_BULK);
    add_iface(6, 8'h04, CLASS_COMM, SUBCLASS_ACM); // subclass byte missing
    add_ep(7, 8'h89, XFER_INT);
    add_ep(3, 8'h8A, XFER_INT);                    // no attribute byte
    add_desc(1, DESC_TYPE_EP, 8'h8B, 8'h03, 8'h00, 8'h00);
    add_ep(4, 8'h8C, XFER_INT);
    add_desc(2, DESC_TYPE_IFACE, 8'h00, 8'h00, 8'h00, 8'h00);
    add_ep(7, 8'h8D, XFER_INT);
    add_iface(7, 8'h06, CLASS_DATA, 8'h00);
    add_ep(7, 8'h8E, XFER_BULK);
    add_ep(7, 8'h0E, XFER_BULK);
    set_total(buf_bytes.size());
    send_buffer(1'b1, buf_bytes.size() - 1);
  endtask

  task automatic test_endpoint_before_iface();
    start_config(9);
    add_ep(7, 8'h81, XFER_BULK);
    add_ep(7, 8'h02, XFER_BULK);
    add_ep(7, 8'h83, XFER_INT);
    add_iface(9, 8'h00, CLASS_COMM, SUBCLASS_ACM);
    add_iface(9, 8'h01, CLASS_DATA, 8'h00);
    set_total(buf_bytes.size());
    send_buffer(1'b1, -1);
  endtask

  task automatic test_status_codes();
    // communication interface with a non-ACM subclass
    start_config(9);
    add_iface(9, 8'h00, CLASS_COMM, 8'h03);
    add_ep(7, 8'h81, XFER_INT);
    add_iface(9, 8'h01, CLASS_DATA, 8'h00);
    add_ep(7, 8'h82, XFER_BULK);
    add_ep(7, 8'h02, XFER_BULK);
    set_total(buf_bytes.size());
    send_buffer(1'b1, -1);
    // bulk OUT missing
    start_config(9);
    add_iface(9, 8'h00, CLASS_COMM, SUBCLASS_ACM);
    add_iface(9, 8'h01, CLASS_DATA, 8'h00);
    add_ep(7, 8'h82, XFER_BULK);
    set_total(buf_bytes.size());
    send_buffer(1'b1, -1);
    // last match wins; wrong direction or transfer type is skipped
    start_config(9);
    add_iface(9, 8'h02, CLASS_COMM, SUBCLASS_ACM);
    add_ep(7, 8'h03, XFER_INT);
    add_ep(7, 8'h85, XFER_BULK);
    add_ep(7, 8'h81, XFER_INT);
    add_ep(7, 8'h84, XFER_INT);
    add_iface(9, 8'h03, CLASS_DATA, 8'h00);
    add_ep(7, 8'h82, XFER_BULK);
    add_ep(7, 8'h86, XFER_ISO);
    add_ep(7, 8'h01, XFER_BULK);
    add_iface(9, 8'h07, CLASS_DATA, 8'h00);
    add_ep(7, 8'h0F, XFER_BULK);
    add_ep(7, 8'h8E, XFER_BULK);
    set_total(buf_bytes.size());
    send_buffer(1'b1, -1);
  endtask

  task automatic test_cut_by_buffer_end();
    build_standard(8'h01, 8'h02, 8'h81, 8'h82, 8'h03);
    send_buffer(1'b1, buf_bytes.size() - 20);   // lands inside the data interface
    build_standard(8'h01, 8'h02, 8'h81, 8'h82, 8'h03);
    send_buffer(1'b1, 1);
  endtask

  task automatic test_restart_mid_walk();
    build_standard(8'h0C, 8'h0D, 8'h8C, 8'h8D, 8'h0D);
    repeat (30) void'(buf_bytes.pop_back());
    send_buffer(1'b1, -1);
    build_standard(8'h0E, 8'h0F, 8'h8E, 8'h8F, 8'h0F);
    send_buffer(1'b1, -1);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int n;
    int sel;
    int eob_at;
    n = 0;
    while (sent_items < ITEM_TARGET) begin
      n++;
      if (n % 15 == 0) wait_drained();
      sel = $urandom_range(99);
      if (sel < 70) begin
        build_random_config();
        if ($urandom_range(3) == 0 && buf_bytes.size() > 5)
          repeat ($urandom_range(1, 3))
            buf_bytes[$urandom_range(4, buf_bytes.size() - 1)] = rand_byte();
        if ($urandom_range(4) == 0) set_total($urandom_range(0, buf_bytes.size() + 20));
      end else if (sel < 88) begin
        buf_bytes.delete();
        repeat ($urandom_range(1, 40)) buf_bytes.push_back(rand_byte());
      end else begin
        // stray bytes without restart: ignored after a result, else they extend the walk
        repeat ($urandom_range(1, 8)) send_byte(rand_byte(), 1'b0, $urandom_range(3) == 0);
        continue;
      end
      case ($urandom_range(5))
        0: eob_at = -1;
        1: eob_at = $urandom_range(buf_bytes.size() - 1);
        default: eob_at = buf_bytes.size() - 1;
      endcase
      if ($urandom_range(5) == 0) begin
        repeat ($urandom_range(1, 6)) buf_bytes.push_back(rand_byte());
        if (eob_at == -1) eob_at = buf_bytes.size() - 1;
      end
      send_buffer(1'b1, eob_at);
    end
  endtask

  initial begin
    walk_clear();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_no_restart_after_reset();
    test_standard_config();
    // a long stretch with no idling on either side
    steady_flow = 1'b1;
    test_short_header();
    test_header_reaches_total();
    steady_flow = 1'b0;
    test_zero_length();
    test_short_descriptors();
    test_endpoint_before_iface();
    test_status_codes();
    test_cut_by_buffer_end();
    test_restart_mid_walk();
    test_random_traffic();
    wait_drained();
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0)
      log_error($sformatf("%0d results never arrived", pending_results.size()));
    if (error_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> files.f
rtl/core/usbcdc_pkg.sv
rtl/core/usb_cdc_acm_descriptor_walker_unit.sv
sim/usb_cdc_acm_descriptor_walker_unit_tb.sv
